@@ design/teq_pkg.sv @@
// Package for the timed event queue: sizes, entry and port types, status
// codes, and the circular index helper.
// Depends on nothing; every other design file imports it.
package teq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int TAG_BITS     = 8;
   localparam int MAX_POPS     = 16;
   localparam int TIME_BITS    = 32;
   localparam int IDX_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int POP_BITS     = $clog2(MAX_POPS + 1);
   localparam int POP_IDX_BITS = (MAX_POPS > 1) ? $clog2(MAX_POPS) : 1;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [TAG_BITS-1:0]  tag_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   // Operation codes of an input item.
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_JUMP    = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;
   localparam logic [1:0] OP_REBASE  = 2'd3;

   // Status codes of a result item.
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_POPPED = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      time_type due;
      tag_type  tag;
   } entry_type;

   typedef struct packed {
      logic      en;
      idx_type   addr;
      entry_type data;
   } wr_type;

   typedef struct packed {
      time_type a;
      time_type b;
      logic     sub;
   } alu_req_type;

   typedef struct packed {
      time_type result;
      logic     a_gt_b;
   } alu_rsp_type;

   // Physical slot of the entry at a given position behind the head.
   function automatic idx_type slot_of(input idx_type head, input cnt_type pos);
      logic [CNT_BITS:0] sum;
      sum = (CNT_BITS + 1)'(head) + (CNT_BITS + 1)'(pos);
      if (sum >= (CNT_BITS + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_BITS + 1)'(QUEUE_DEPTH);
      end
      return sum[IDX_BITS-1:0];
   endfunction

endpackage

@@ design/teq_store.sv @@
// Entry memory of the timed event queue: one write port, one read port with
// registered read data.
// Depends on teq_pkg.
module teq_store (
   input  logic               clock,
   input  teq_pkg::wr_type    wr,
   input  teq_pkg::idx_type   raddr,
   output teq_pkg::entry_type rdata
);
   import teq_pkg::*;

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/teq_alu.sv @@
// Shared time unit of the timed event queue: one 32-bit add or subtract and
// one unsigned greater-than compare.
// Depends on teq_pkg.
module teq_alu (
   input  teq_pkg::alu_req_type req,
   output teq_pkg::alu_rsp_type rsp
);
   import teq_pkg::*;

   always_comb begin
      rsp.result = req.sub ? (req.a - req.b) : (req.a + req.b);
      rsp.a_gt_b = (req.a > req.b);
   end

endmodule

@@ design/timed_event_queue.sv @@
// Top level of the timed event queue: sequencer, time and count registers,
// and result channel. Uses teq_store for the entries and teq_alu for time math.
// Depends on teq_pkg, teq_store and teq_alu.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  operation, delay, event_tag
//   rsp_      out        rsp_valid/rsp_stall  status, popped_tag, last,
//                                             current_time, next_due, occupancy
//
// One item is worked at a time; req_stall stays high until its last result
// item has been taken, and the next item is accepted in the cycle after that.
// Advance and the rejected or empty cases pass through S_FIN_RD and S_FIN_WAIT
// to their result. Insert and rebase walk every entry through the single
// memory read port, with a read state and a compare or write state per entry,
// before that same finish. Jump reads and pops events one at a time, then
// delivers one result per popped event, each held while rsp_stall is high.
// Reset is synchronous and clears the sequencer, the head, the count and now;
// the entry memory is not cleared, as only entries inside the count are read.
// A stalled result holds all of its fields unchanged.
module timed_event_queue (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_delay,
   input  logic [7:0]  req_event_tag,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_popped_tag,
   output logic        rsp_last,
   output logic [31:0] rsp_current_time,
   output logic [31:0] rsp_next_due,
   output logic [4:0]  rsp_occupancy
);
   import teq_pkg::*;

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INS_RD   = 4'd1;
   localparam logic [3:0] S_INS_CMP  = 4'd2;
   localparam logic [3:0] S_RB_RD    = 4'd3;
   localparam logic [3:0] S_RB_WR    = 4'd4;
   localparam logic [3:0] S_JP_RD    = 4'd5;
   localparam logic [3:0] S_JP_CMP   = 4'd6;
   localparam logic [3:0] S_FIN_RD   = 4'd7;
   localparam logic [3:0] S_FIN_WAIT = 4'd8;
   localparam logic [3:0] S_EMIT     = 4'd9;

   logic [3:0]          state_ff, state_in;
   idx_type             head_ff, head_in;
   cnt_type             count_ff, count_in;
   time_type            now_ff, now_in;
   time_type            due_ff, due_in;        // due time of the entry being carried
   tag_type             tag_ff, tag_in;        // tag of the entry being carried
   cnt_type             pos_ff, pos_in;        // walk position behind the head
   logic                placed_ff, placed_in;  // new event already written
   logic [1:0]          status_ff, status_in;
   time_type            next_due_ff, next_due_in;
   logic [POP_BITS-1:0] npop_ff, npop_in;      // events popped by this jump
   logic [POP_BITS-1:0] rsp_idx_ff, rsp_idx_in; // result being delivered
   logic                first_ff, first_in;    // first pop of a jump sets now
   tag_type             popped_ff [MAX_POPS];
   logic                pop_wr;

   wr_type      wr;
   idx_type     raddr;
   entry_type   rdata;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic req_take;
   logic rsp_take;
   logic is_last;

   teq_store u_store (
      .clock (clock),
      .wr    (wr),
      .raddr (raddr),
      .rdata (rdata)
   );

   teq_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_EMIT);
   assign rsp_take  = rsp_valid && !rsp_stall;

   // A jump delivers one result per popped event; every other item one result.
   assign is_last = (status_ff != ST_POPPED) || (rsp_idx_ff == npop_ff - POP_BITS'(1));

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      now_in      = now_ff;
      due_in      = due_ff;
      tag_in      = tag_ff;
      pos_in      = pos_ff;
      placed_in   = placed_ff;
      status_in   = status_ff;
      next_due_in = next_due_ff;
      npop_in     = npop_ff;
      rsp_idx_in  = rsp_idx_ff;
      first_in    = first_ff;
      pop_wr      = 1'b0;

      wr.en      = 1'b0;
      wr.addr    = slot_of(head_ff, pos_ff);
      wr.data    = rdata;
      raddr      = slot_of(head_ff, cnt_type'(0));
      alu_req.a   = now_ff;
      alu_req.b   = req_delay;
      alu_req.sub = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               status_in = ST_DONE;
               case (req_operation)
                  OP_INSERT: begin
                     due_in    = alu_rsp.result;
                     tag_in    = tag_type'(req_event_tag);
                     pos_in    = '0;
                     placed_in = 1'b0;
                     if (count_ff == cnt_type'(QUEUE_DEPTH)) begin
                        status_in = ST_FULL;
                        state_in  = S_FIN_RD;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  OP_JUMP: begin
                     npop_in  = '0;
                     first_in = 1'b1;
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_FIN_RD;
                     end else begin
                        status_in = ST_POPPED;
                        state_in  = S_JP_RD;
                     end
                  end
                  OP_ADVANCE: begin
                     now_in   = alu_rsp.result;
                     state_in = S_FIN_RD;
                  end
                  OP_REBASE: begin
                     pos_in   = '0;
                     state_in = S_RB_RD;
                  end
                  default: begin
                     state_in = S_FIN_RD;
                  end
               endcase
            end
         end

         // Walk from the head. The new event takes the slot of the first entry
         // due later than it, and from there every entry moves back one slot,
         // carried in due_ff and tag_ff. The list is taken in the order it
         // stands, which need not be sorted once a rebase has wrapped entries.
         S_INS_RD: begin
            if (pos_ff == count_ff) begin
               wr.en       = 1'b1;
               wr.data.due = due_ff;
               wr.data.tag = tag_ff;
               count_in    = count_ff + cnt_type'(1);
               state_in    = S_FIN_RD;
            end else begin
               raddr    = slot_of(head_ff, pos_ff);
               state_in = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            alu_req.a = rdata.due;
            alu_req.b = due_ff;
            // Equal due times stay ahead of the new event.
            if (placed_ff || alu_rsp.a_gt_b) begin
               wr.en       = 1'b1;
               wr.data.due = due_ff;
               wr.data.tag = tag_ff;
               due_in      = rdata.due;
               tag_in      = rdata.tag;
               placed_in   = 1'b1;
            end
            pos_in   = pos_ff + cnt_type'(1);
            state_in = S_INS_RD;
         end

         S_RB_RD: begin
            if (pos_ff == count_ff) begin
               now_in   = '0;
               state_in = S_FIN_RD;
            end else begin
               raddr    = slot_of(head_ff, pos_ff);
               state_in = S_RB_WR;
            end
         end

         S_RB_WR: begin
            alu_req.a   = rdata.due;
            alu_req.b   = now_ff;
            alu_req.sub = 1'b1;
            wr.en       = 1'b1;
            wr.data.due = alu_rsp.result;
            pos_in      = pos_ff + cnt_type'(1);
            state_in    = S_RB_RD;
         end

         S_JP_RD: begin
            if ((count_ff == '0) || (npop_ff == POP_BITS'(MAX_POPS))) begin
               state_in = S_FIN_RD;
            end else begin
               state_in = S_JP_CMP;
            end
         end

         // The first pop moves now to the head's due time; later pops need
         // a due time not above now.
         S_JP_CMP: begin
            alu_req.a = rdata.due;
            alu_req.b = now_ff;
            if (first_ff || !alu_rsp.a_gt_b) begin
               if (first_ff) begin
                  now_in = rdata.due;
               end
               pop_wr   = 1'b1;
               npop_in  = npop_ff + POP_BITS'(1);
               head_in  = slot_of(head_ff, cnt_type'(1));
               count_in = count_ff - cnt_type'(1);
               first_in = 1'b0;
               state_in = S_JP_RD;
            end else begin
               state_in = S_FIN_RD;
            end
         end

         S_FIN_RD: begin
            state_in = S_FIN_WAIT;
         end

         S_FIN_WAIT: begin
            next_due_in = (count_ff != '0) ? rdata.due : '0;
            rsp_idx_in  = '0;
            state_in    = S_EMIT;
         end

         S_EMIT: begin
            if (rsp_take) begin
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  rsp_idx_in = rsp_idx_ff + POP_BITS'(1);
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         now_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         now_ff   <= now_in;
      end
   end

   always_ff @(posedge clock) begin
      due_ff      <= due_in;
      tag_ff      <= tag_in;
      pos_ff      <= pos_in;
      placed_ff   <= placed_in;
      status_ff   <= status_in;
      next_due_ff <= next_due_in;
      npop_ff     <= npop_in;
      rsp_idx_ff  <= rsp_idx_in;
      first_ff    <= first_in;
      if (pop_wr) begin
         popped_ff[npop_ff[POP_IDX_BITS-1:0]] <= rdata.tag;
      end
   end

   // Every result of an item reports the state after the whole operation.
   assign rsp_status       = status_ff;
   assign rsp_popped_tag   = (status_ff == ST_POPPED) ?
                             8'(popped_ff[rsp_idx_ff[POP_IDX_BITS-1:0]]) : 8'd0;
   assign rsp_last         = is_last;
   assign rsp_current_time = now_ff;
   assign rsp_next_due     = next_due_ff;
   assign rsp_occupancy    = 5'(count_ff);

endmodule
